>>> rtl/gbn_pkg.sv
// Shared types and constants for the go-back-N sender window.
// Used by the controller, the datapath and the top level.
package gbn_pkg;

  localparam int SEQ_W          = 3;
  localparam int WIN_W          = 4;
  localparam int TMO_W          = 16;
  localparam int MODE_W         = 2;
  localparam int ACT_W          = 3;
  localparam int SEQ_CAP        = 8;
  localparam int CFG_IDX_W      = 1;
  localparam int DEF_MAX_WINDOW = 8;
  localparam int DEF_DATA_WIDTH = 32;

  localparam logic [WIN_W-1:0] WINDOW_RESET  = WIN_W'(4);
  localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(6);

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFFER = 2'd0,
    MODE_ACK   = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE    = 3'd0,
    ACT_SEND    = 3'd1,
    ACT_RESEND  = 3'd2,
    ACT_DELIVER = 3'd3,
    ACT_REFUSE  = 3'd4
  } action_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_t;

  typedef struct packed {
    logic send;
    logic refuse;
    logic deliver;
    logic ack_any;
    logic tick;
    logic start_resend;
    logic quiet;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic has_out;
    logic ack_match;
    logic armed;
    logic expire;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

>>> rtl/go_back_n_sender_window.sv
// Go-back-N ARQ sender window, top level.
// Depends on gbn_pkg, gbn_ctrl, gbn_dpath and gbn_ram.
//
// Each request is an offered payload, an acknowledgement or a time tick, selected by
// s_tuser. Offers, matching acknowledgements, plain ticks and ignored requests give one
// result each. An acknowledgement that does not match, or a tick that expires the timer,
// resends every outstanding frame from the oldest: that request starts the burst, which
// then gives one result per frame, paced by the single read port of the frame store and
// by the output, which can stall it. The last result of each request carries m_tlast.
// A result register sits on the output, so a new request is taken while the previous
// result is being handed over. The frame store needs no clearing after reset. Write
// configuration only while the block is idle; writing the window size restarts sequence
// numbering and drops all outstanding frames.
module go_back_n_sender_window #(
  parameter int MAX_WINDOW = gbn_pkg::DEF_MAX_WINDOW,
  parameter int DATA_WIDTH = gbn_pkg::DEF_DATA_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // payload, ack_seq, zero fill
  input  logic [((DATA_WIDTH + gbn_pkg::SEQ_W + 7) / 8) * 8 - 1:0] s_tdata,
  // mode
  input  logic [gbn_pkg::MODE_W-1:0]          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // frame_seq, frame_data, in_flight, zero fill
  output logic [((DATA_WIDTH + gbn_pkg::SEQ_W + gbn_pkg::WIN_W + 7) / 8) * 8 - 1:0] m_tdata,
  // action
  output logic [gbn_pkg::ACT_W-1:0]           m_tuser,
  output logic                                m_tlast,
  input  logic                                cfg_we,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gbn_pkg::TMO_W-1:0]           cfg_data
);
  import gbn_pkg::*;

  localparam int OutTdataW = ((DATA_WIDTH + SEQ_W + WIN_W + 7) / 8) * 8;

  cmd_t                  cmd;
  status_t               stat;
  mode_t                 mode;
  action_t               out_action;
  logic [SEQ_W-1:0]      out_seq;
  logic [DATA_WIDTH-1:0] out_data;
  logic [WIN_W-1:0]      out_flight;

  assign mode = mode_t'(s_tuser);

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .mode     (mode),
    .stat     (stat),
    .cmd      (cmd)
  );

  gbn_dpath #(
    .MAX_WINDOW (MAX_WINDOW),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_payload (s_tdata[DATA_WIDTH-1:0]),
    .in_ack_seq (s_tdata[DATA_WIDTH +: SEQ_W]),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_action (out_action),
    .out_seq    (out_seq),
    .out_data   (out_data),
    .out_flight (out_flight),
    .out_last   (m_tlast)
  );

  assign m_tuser = out_action;
  assign m_tdata = OutTdataW'({out_flight, out_data, out_seq});

endmodule

>>> rtl/gbn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gbn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/gbn_ctrl.sv
// Controller state machine: decodes requests and sequences resend bursts.
// Depends on gbn_pkg.
module gbn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  gbn_pkg::mode_t    mode,
  input  gbn_pkg::status_t  stat,
  output gbn_pkg::cmd_t     cmd
);
  import gbn_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = stat.out_free;
        if (s_tvalid && stat.out_free) begin
          case (mode)
            MODE_OFFER: begin
              if (stat.full) begin
                cmd.refuse = 1'b1;
              end else begin
                cmd.send = 1'b1;
              end
            end
            MODE_ACK: begin
              if (stat.has_out) begin
                cmd.ack_any = 1'b1;
                if (stat.ack_match) begin
                  cmd.deliver = 1'b1;
                end else begin
                  cmd.start_resend = 1'b1;
                  state_next       = ST_EMIT;
                end
              end else begin
                cmd.quiet = 1'b1;
              end
            end
            MODE_TICK: begin
              if (stat.armed) begin
                cmd.tick = 1'b1;
                if (stat.expire && stat.has_out) begin
                  cmd.start_resend = 1'b1;
                  state_next       = ST_EMIT;
                end else begin
                  cmd.quiet = 1'b1;
                end
              end else begin
                cmd.quiet = 1'b1;
              end
            end
            default: begin
              cmd.quiet = 1'b1;
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/gbn_dpath.sv
// Datapath: window registers, retransmission timer, frame store and result register.
// Depends on gbn_pkg and gbn_ram.
module gbn_dpath #(
  parameter int MAX_WINDOW = gbn_pkg::DEF_MAX_WINDOW,
  parameter int DATA_WIDTH = gbn_pkg::DEF_DATA_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gbn_pkg::TMO_W-1:0]       cfg_data,
  input  logic [DATA_WIDTH-1:0]           in_payload,
  input  logic [gbn_pkg::SEQ_W-1:0]       in_ack_seq,
  input  gbn_pkg::cmd_t                   cmd,
  output gbn_pkg::status_t                stat,
  output logic                            out_valid,
  input  logic                            out_ready,
  output gbn_pkg::action_t                out_action,
  output logic [gbn_pkg::SEQ_W-1:0]       out_seq,
  output logic [DATA_WIDTH-1:0]           out_data,
  output logic [gbn_pkg::WIN_W-1:0]       out_flight,
  output logic                            out_last
);
  import gbn_pkg::*;

  localparam int WinCap = (MAX_WINDOW < SEQ_CAP) ? MAX_WINDOW : SEQ_CAP;
  localparam int IdxW   = $clog2(WinCap);
  localparam logic [WIN_W-1:0] WinCapV = WIN_W'(WinCap);

  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s,
                                               input logic [WIN_W-1:0] w);
    logic [WIN_W-1:0] s1;
    s1 = WIN_W'(s) + 1'b1;
    return (s1 >= w) ? '0 : s1[SEQ_W-1:0];
  endfunction

  logic [WIN_W-1:0] window_size;
  logic [TMO_W-1:0] timeout_ticks;
  logic [SEQ_W-1:0] base_seq;
  logic [SEQ_W-1:0] next_seq;
  logic [WIN_W-1:0] outstanding;
  logic [TMO_W-1:0] timer_count;
  logic             timer_armed;
  logic [SEQ_W-1:0] emit_seq;
  logic [WIN_W-1:0] remain;

  logic [WIN_W-1:0] eff_win;
  logic [SEQ_W-1:0] base_inc;
  logic [SEQ_W-1:0] next_inc;
  logic [SEQ_W-1:0] emit_inc;
  logic [TMO_W-1:0] timer_inc;
  logic [TMO_W-1:0] tmo;
  logic             load;

  logic             rd_en;
  logic [IdxW-1:0]  rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;

  always_comb begin
    if (window_size == '0) begin
      eff_win = WIN_W'(1);
    end else if (window_size > WinCapV) begin
      eff_win = WinCapV;
    end else begin
      eff_win = window_size;
    end
  end

  assign base_inc  = seq_inc(base_seq, eff_win);
  assign next_inc  = seq_inc(next_seq, eff_win);
  assign emit_inc  = seq_inc(emit_seq, eff_win);
  assign timer_inc = timer_count + 1'b1;
  assign tmo       = (timeout_ticks == '0) ? TMO_W'(1) : timeout_ticks;

  assign stat.full      = (outstanding >= eff_win);
  assign stat.has_out   = (outstanding != '0);
  assign stat.ack_match = (in_ack_seq == base_inc);
  assign stat.armed     = timer_armed;
  assign stat.expire    = (timer_inc >= tmo) || (timer_inc == '0);
  assign stat.emit_last = (remain == WIN_W'(1));
  assign stat.out_free  = !out_valid || out_ready;

  assign load    = cmd.send | cmd.refuse | cmd.deliver | cmd.quiet | cmd.emit;
  assign rd_en   = cmd.start_resend | (cmd.emit & ~stat.emit_last);
  assign rd_addr = cmd.start_resend ? base_seq[IdxW-1:0] : emit_inc[IdxW-1:0];

  gbn_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (WinCap)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.send),
    .wr_addr (next_seq[IdxW-1:0]),
    .wr_data (in_payload),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= WINDOW_RESET;
      timeout_ticks <= TIMEOUT_RESET;
      base_seq      <= '0;
      next_seq      <= '0;
      outstanding   <= '0;
      timer_count   <= '0;
      timer_armed   <= 1'b0;
      remain        <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_WINDOW_SIZE) begin
          window_size <= cfg_data[WIN_W-1:0];
          base_seq    <= '0;
          next_seq    <= '0;
          outstanding <= '0;
          timer_count <= '0;
          timer_armed <= 1'b0;
        end else begin
          timeout_ticks <= cfg_data;
        end
      end else begin
        if (cmd.send) begin
          next_seq    <= next_inc;
          outstanding <= outstanding + 1'b1;
          if (!timer_armed) begin
            timer_armed <= 1'b1;
            timer_count <= '0;
          end
        end
        if (cmd.ack_any) begin
          timer_count <= '0;
          if (cmd.deliver) begin
            base_seq    <= base_inc;
            outstanding <= outstanding - 1'b1;
            timer_armed <= (outstanding != WIN_W'(1));
          end else begin
            timer_armed <= 1'b1;
          end
        end
        if (cmd.tick) begin
          timer_count <= stat.expire ? '0 : timer_inc;
        end
        if (cmd.start_resend) begin
          remain <= outstanding;
        end
        if (cmd.emit) begin
          remain <= remain - 1'b1;
        end
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_resend) begin
      emit_seq <= base_seq;
    end else if (cmd.emit) begin
      emit_seq <= emit_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.send) begin
      out_action <= ACT_SEND;
      out_seq    <= next_seq;
      out_data   <= in_payload;
      out_flight <= outstanding + 1'b1;
      out_last   <= 1'b1;
    end else if (cmd.refuse) begin
      out_action <= ACT_REFUSE;
      out_seq    <= '0;
      out_data   <= '0;
      out_flight <= outstanding;
      out_last   <= 1'b1;
    end else if (cmd.deliver) begin
      out_action <= ACT_DELIVER;
      out_seq    <= '0;
      out_data   <= in_payload;
      out_flight <= outstanding - 1'b1;
      out_last   <= 1'b1;
    end else if (cmd.emit) begin
      out_action <= ACT_RESEND;
      out_seq    <= emit_seq;
      out_data   <= rd_data;
      out_flight <= outstanding;
      out_last   <= stat.emit_last;
    end else if (cmd.quiet) begin
      out_action <= ACT_NONE;
      out_seq    <= '0;
      out_data   <= '0;
      out_flight <= outstanding;
      out_last   <= 1'b1;
    end
  end

endmodule
